/* rtl/mlfq_pkg.sv */
// Types and codes shared by the multilevel feedback queue scheduler.
`default_nettype none

package mlfq_pkg;

  localparam logic [1:0] KIND_ADMIT   = 2'd0;
  localparam logic [1:0] KIND_REQUEUE = 2'd1;
  localparam logic [1:0] KIND_POP     = 2'd2;

  localparam int unsigned FIELD_ID_W  = 16;
  localparam int unsigned FIELD_LVL_W = 2;

  typedef enum logic [1:0] {
    STATUS_ENQUEUED = 2'd0,
    STATUS_DEQUEUED = 2'd1,
    STATUS_EMPTY    = 2'd2,
    STATUS_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [FIELD_ID_W-1:0] process_id;
    logic [1:0]            priority_req;
  } mlfq_in_t;

  typedef struct packed {
    status_t                status;
    logic [FIELD_ID_W-1:0]  out_process_id;
    logic [FIELD_LVL_W-1:0] out_level;
  } mlfq_out_t;

  typedef struct packed {
    logic    res;
    logic    wr;
    logic    rd;
    status_t status;
  } mlfq_dec_t;

endpackage

`default_nettype wire

/* rtl/multilevel_feedback_queue_top.sv */
// Top level of the multilevel feedback queue scheduler: input register, queue store and result register.
`default_nettype none

// Keeps NUM_LEVELS FIFO queues of process identifiers in one store, level 0 served first. Each
// transfer on the input channel is an admit, a requeue (middle levels demoted by one) or a pop,
// and gives one result transfer; kind 3 gives none. An item passes from input transfer to result
// through the input register, where the pointers and fill counts are consulted and the store is
// written or read, and then the result register, which also holds the registered read data of
// the store's single port. One item is taken every cycle while the result side keeps up.
// The store needs no clearing after reset; items are accepted from the first cycle.
module multilevel_feedback_queue_top import mlfq_pkg::*; #(
  parameter int NUM_LEVELS  = 4,
  parameter int QUEUE_DEPTH = 256,
  parameter int ID_WIDTH    = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire mlfq_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output mlfq_out_t      out_data
);

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W = LVL_W + PTR_W;
  localparam int SW     = (ID_WIDTH < FIELD_ID_W) ? ID_WIDTH : FIELD_ID_W;

  logic                   s1_valid_r;
  mlfq_in_t               s1_item_r;
  logic                   s2_valid_r;
  status_t                s2_status_r;
  logic [FIELD_LVL_W-1:0] s2_level_r;
  logic [SW-1:0]          rd_data_r;

  logic             s2_free;
  logic             commit;
  mlfq_dec_t        dec;
  logic [LVL_W-1:0] level;
  logic [PTR_W-1:0] ptr;
  logic [ADDR_W-1:0] addr;

  logic [SW-1:0] mem [1 << ADDR_W];

  assign s2_free  = !s2_valid_r || out_ready;
  assign commit   = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s2_free;

  mlfq_ctrl #(
    .NUM_LEVELS  (NUM_LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LVL_W       (LVL_W),
    .PTR_W       (PTR_W)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (commit),
    .item   (s1_item_r),
    .dec    (dec),
    .level  (level),
    .ptr    (ptr)
  );

  assign addr = {level, ptr};

  always_ff @(posedge clk) begin
    if (commit && dec.wr) begin
      mem[addr] <= s1_item_r.process_id[SW-1:0];
    end
    if (commit && dec.rd) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_valid_r && dec.res;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      s2_status_r <= dec.status;
      s2_level_r  <= FIELD_LVL_W'(level);
    end
  end

  assign out_valid               = s2_valid_r;
  assign out_data.status         = s2_status_r;
  assign out_data.out_level      = s2_level_r;
  assign out_data.out_process_id = (s2_status_r == STATUS_DEQUEUED) ?
                                   FIELD_ID_W'(rd_data_r) : '0;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s2_valid_r && !out_ready))
    else $error("Input side stalled while the pipeline had room.");

  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STATUS_EMPTY) |->
      (out_data.out_process_id == '0 && out_data.out_level == '0))
    else $error("Empty pop result carries a nonzero identifier or level.");

  a_read_gives_dequeue: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && dec.rd) |=> (out_valid && out_data.status == STATUS_DEQUEUED))
    else $error("Store read did not produce a dequeue result.");

  a_no_access_clash: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> !(dec.wr && dec.rd))
    else $error("Store written and read for the same transfer.");

endmodule

`default_nettype wire

/* rtl/mlfq_ctrl.sv */
// Queue pointers and fill counts, with the decision taken for the item in the input register.
`default_nettype none

module mlfq_ctrl import mlfq_pkg::*; #(
  parameter int NUM_LEVELS  = 4,
  parameter int QUEUE_DEPTH = 256,
  parameter int LVL_W       = 2,
  parameter int PTR_W       = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             commit,
  input  wire mlfq_in_t         item,
  output mlfq_dec_t             dec,
  output logic      [LVL_W-1:0] level,
  output logic      [PTR_W-1:0] ptr
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [PTR_W-1:0] head_r [NUM_LEVELS];
  logic [PTR_W-1:0] tail_r [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_r  [NUM_LEVELS];

  logic             found;
  logic [LVL_W-1:0] pop_lvl;
  logic [LVL_W-1:0] enq_lvl;
  logic [LVL_W-1:0] sat_lvl;
  logic [2:0]       req3;
  logic [PTR_W-1:0] ptr_nxt;

  always_comb begin
    found   = 1'b0;
    pop_lvl = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (cnt_r[l] != '0) begin
        found   = 1'b1;
        pop_lvl = LVL_W'(l);
      end
    end
  end

  always_comb begin
    req3 = {1'b0, item.priority_req};
    if (int'(req3) >= NUM_LEVELS) begin
      sat_lvl = LVL_W'(NUM_LEVELS - 1);
    end else begin
      sat_lvl = req3[LVL_W-1:0];
    end
    if (item.kind == KIND_REQUEUE && sat_lvl != '0 && int'(sat_lvl) < NUM_LEVELS - 1) begin
      enq_lvl = sat_lvl + 1'b1;
    end else begin
      enq_lvl = sat_lvl;
    end
  end

  always_comb begin
    dec        = '0;
    dec.status = STATUS_ENQUEUED;
    level      = enq_lvl;
    ptr        = tail_r[enq_lvl];
    unique case (item.kind)
      KIND_ADMIT, KIND_REQUEUE: begin
        dec.res = 1'b1;
        if (cnt_r[enq_lvl] == CNT_W'(QUEUE_DEPTH)) begin
          dec.status = STATUS_FULL;
        end else begin
          dec.wr = 1'b1;
        end
      end
      KIND_POP: begin
        dec.res = 1'b1;
        level   = pop_lvl;
        ptr     = head_r[pop_lvl];
        if (found) begin
          dec.rd     = 1'b1;
          dec.status = STATUS_DEQUEUED;
        end else begin
          level      = '0;
          dec.status = STATUS_EMPTY;
        end
      end
      default: begin
        dec.res = 1'b0;
      end
    endcase
  end

  assign ptr_nxt = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else if (commit) begin
      if (dec.wr) begin
        tail_r[level] <= ptr_nxt;
        cnt_r[level]  <= cnt_r[level] + 1'b1;
      end else if (dec.rd) begin
        head_r[level] <= ptr_nxt;
        cnt_r[level]  <= cnt_r[level] - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
